### rtl/dmfe_pkg.sv
// Shared types and constants for the DHCP message field extractor.
package dmfe_pkg;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  // result kinds
  localparam logic [3:0] KIND_OP       = 4'd0;
  localparam logic [3:0] KIND_HTYPE    = 4'd1;
  localparam logic [3:0] KIND_HLEN     = 4'd2;
  localparam logic [3:0] KIND_XID      = 4'd3;
  localparam logic [3:0] KIND_CHADDR   = 4'd4;
  localparam logic [3:0] KIND_HOSTNAME = 4'd5;
  localparam logic [3:0] KIND_MSGTYPE  = 4'd6;
  localparam logic [3:0] KIND_VENDOR   = 4'd7;
  localparam logic [3:0] KIND_CLIENTID = 4'd8;
  localparam logic [3:0] KIND_FINAL    = 4'd9;

  // final status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_PARTIAL   = 2'd1;
  localparam logic [1:0] STAT_MALFORMED = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_HOSTNAME_CAP = 2'd0;
  localparam logic [1:0] CFG_VENDOR_CAP   = 2'd1;
  localparam logic [1:0] CFG_CLIENT_ID_MAX = 2'd2;

  localparam logic [7:0] HOSTNAME_CAP_RST = 8'd64;
  localparam logic [7:0] VENDOR_CAP_RST   = 8'd64;
  localparam logic [7:0] CLIENT_ID_RST    = 8'd32;

  typedef struct packed {
    logic [3:0]  kind;
    logic [7:0]  element_index;
    logic [31:0] fact_value;
    logic [1:0]  status;
    logic        options_end_seen;
    logic        hostname_cut;
    logic        vendor_class_cut;
    logic        client_id_cut;
    logic        final_item;
  } result_t;

  typedef struct packed {
    logic [7:0] hostname_cap;
    logic [7:0] vendor_class_cap;
    logic [7:0] client_id_max;
  } cfg_t;

endpackage

### rtl/dmfe_parse.sv
// Byte-wise DHCP parser core: message state and up to two results per byte.
module dmfe_parse import dmfe_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  input  cfg_t       cfg_i,
  output logic       fact_v_o,
  output result_t    fact_o,
  output logic       fin_v_o,
  output result_t    fin_o
);

  typedef enum logic [2:0] {
    PH_HEADER, PH_CODE, PH_LEN, PH_VALUE, PH_ENDED, PH_SKIP
  } phase_t;

  localparam logic [7:0]  OPT_PAD      = 8'd0;
  localparam logic [7:0]  OPT_END      = 8'd255;
  localparam logic [7:0]  OPT_HOSTNAME = 8'd12;
  localparam logic [7:0]  OPT_MSGTYPE  = 8'd53;
  localparam logic [7:0]  OPT_VENDOR   = 8'd60;
  localparam logic [7:0]  OPT_CLIENTID = 8'd61;
  localparam logic [7:0]  POS_CHADDR   = 8'd28;
  localparam logic [7:0]  POS_COOKIE   = 8'd236;
  localparam logic [7:0]  POS_LAST_HDR = 8'd239;
  localparam logic [7:0]  CHADDR_MAX   = 8'd16;
  localparam logic [31:0] COOKIE       = 32'h6382_5363;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  pos_r, pos_nxt;
  logic [7:0]  hwlen_r, hwlen_nxt;
  logic [23:0] xid_r, xid_nxt;
  logic [7:0]  code_r, code_nxt;
  logic [7:0]  left_r, left_nxt;
  logic [7:0]  idx_r, idx_nxt;
  logic        zs_r, zs_nxt;
  logic        mal_r, mal_nxt, part_r, part_nxt, end_r, end_nxt;
  logic        hcut_r, hcut_nxt, vcut_r, vcut_nxt, ccut_r, ccut_nxt;

  logic [7:0] host_keep, vend_keep, chaddr_i, cookie_byte, left_dec;
  logic       zs_now;

  assign host_keep = (cfg_i.hostname_cap == 8'd0) ? 8'd0 : cfg_i.hostname_cap - 8'd1;
  assign vend_keep = (cfg_i.vendor_class_cap == 8'd0) ? 8'd0 :
                     cfg_i.vendor_class_cap - 8'd1;
  assign chaddr_i  = pos_r - POS_CHADDR;
  assign left_dec  = left_r - 8'd1;
  assign zs_now    = zs_r | (byte_i == 8'd0);

  always_comb begin
    unique case (pos_r[1:0])
      2'd0:    cookie_byte = COOKIE[31:24];
      2'd1:    cookie_byte = COOKIE[23:16];
      2'd2:    cookie_byte = COOKIE[15:8];
      default: cookie_byte = COOKIE[7:0];
    endcase
  end

  always_comb begin
    phase_nxt = phase_r;  pos_nxt = pos_r;   hwlen_nxt = hwlen_r;
    xid_nxt   = xid_r;    code_nxt = code_r; left_nxt  = left_r;
    idx_nxt   = idx_r;    zs_nxt  = zs_r;
    mal_nxt   = mal_r;    part_nxt = part_r; end_nxt   = end_r;
    hcut_nxt  = hcut_r;   vcut_nxt = vcut_r; ccut_nxt  = ccut_r;
    fact_v_o  = 1'b0;     fact_o  = '0;
    fin_v_o   = 1'b0;     fin_o   = '0;

    if (step_i) begin
      unique case (phase_r)
        PH_HEADER: begin
          if (pos_r == 8'd0) begin
            fact_v_o = 1'b1; fact_o.kind = KIND_OP; fact_o.fact_value = {24'd0, byte_i};
          end else if (pos_r == 8'd1) begin
            fact_v_o = 1'b1; fact_o.kind = KIND_HTYPE; fact_o.fact_value = {24'd0, byte_i};
          end else if (pos_r == 8'd2) begin
            hwlen_nxt = byte_i;
            if (byte_i > CHADDR_MAX) mal_nxt = 1'b1;
            fact_v_o = 1'b1; fact_o.kind = KIND_HLEN; fact_o.fact_value = {24'd0, byte_i};
          end else if (pos_r >= 8'd4 && pos_r <= 8'd6) begin
            xid_nxt = {xid_r[15:0], byte_i};
          end else if (pos_r == 8'd7) begin
            fact_v_o = 1'b1; fact_o.kind = KIND_XID; fact_o.fact_value = {xid_r, byte_i};
          end else if (pos_r >= POS_CHADDR && pos_r < POS_CHADDR + CHADDR_MAX) begin
            if (hwlen_r <= CHADDR_MAX && chaddr_i < hwlen_r) begin
              fact_v_o = 1'b1; fact_o.kind = KIND_CHADDR;
              fact_o.element_index = chaddr_i; fact_o.fact_value = {24'd0, byte_i};
            end
          end else if (pos_r >= POS_COOKIE) begin
            if (byte_i != cookie_byte) mal_nxt = 1'b1;
          end
          if (pos_r >= POS_LAST_HDR) phase_nxt = mal_nxt ? PH_SKIP : PH_CODE;
          else pos_nxt = pos_r + 8'd1;
        end
        PH_CODE: begin
          if (byte_i == OPT_END) begin
            end_nxt = 1'b1;
            phase_nxt = PH_ENDED;
          end else if (byte_i != OPT_PAD) begin
            code_nxt = byte_i;
            phase_nxt = PH_LEN;
          end
        end
        PH_LEN: begin
          if (code_r == OPT_MSGTYPE && byte_i != 8'd1) begin
            mal_nxt = 1'b1;
            phase_nxt = PH_SKIP;
          end else begin
            if (code_r == OPT_HOSTNAME) begin
              hcut_nxt = byte_i > host_keep;
              if (hcut_nxt) part_nxt = 1'b1;
            end else if (code_r == OPT_VENDOR) begin
              vcut_nxt = byte_i > vend_keep;
              if (vcut_nxt) part_nxt = 1'b1;
            end else if (code_r == OPT_CLIENTID) begin
              ccut_nxt = byte_i > cfg_i.client_id_max;
              if (ccut_nxt) part_nxt = 1'b1;
            end
            zs_nxt = 1'b0;
            idx_nxt = 8'd0;
            left_nxt = byte_i;
            phase_nxt = (byte_i == 8'd0) ? PH_CODE : PH_VALUE;
          end
        end
        PH_VALUE: begin
          fact_o.element_index = idx_r;
          fact_o.fact_value = {24'd0, byte_i};
          if (code_r == OPT_HOSTNAME) begin
            zs_nxt = zs_now;
            if (idx_r < host_keep) begin
              fact_v_o = 1'b1; fact_o.kind = KIND_HOSTNAME;
              if (!zs_now && byte_i >= 8'h41 && byte_i <= 8'h5a)
                fact_o.fact_value = {24'd0, byte_i + 8'd32};
            end
          end else if (code_r == OPT_MSGTYPE) begin
            fact_v_o = 1'b1; fact_o.kind = KIND_MSGTYPE; fact_o.element_index = 8'd0;
          end else if (code_r == OPT_VENDOR) begin
            if (idx_r < vend_keep) begin
              fact_v_o = 1'b1; fact_o.kind = KIND_VENDOR;
            end
          end else if (code_r == OPT_CLIENTID) begin
            if (idx_r < cfg_i.client_id_max) begin
              fact_v_o = 1'b1; fact_o.kind = KIND_CLIENTID;
            end
          end
          if (!fact_v_o) fact_o = '0;
          idx_nxt = idx_r + 8'd1;
          left_nxt = left_dec;
          if (left_dec == 8'd0) phase_nxt = PH_CODE;
        end
        default: ;
      endcase

      if (last_i) begin
        // message cut inside the header or inside an option
        if (phase_nxt == PH_HEADER || phase_nxt == PH_LEN || phase_nxt == PH_VALUE)
          mal_nxt = 1'b1;
        fin_v_o = 1'b1;
        fin_o.kind = KIND_FINAL;
        fin_o.status = mal_nxt ? STAT_MALFORMED : (part_nxt ? STAT_PARTIAL : STAT_OK);
        fin_o.options_end_seen = end_nxt;
        fin_o.hostname_cut = hcut_nxt;
        fin_o.vendor_class_cut = vcut_nxt;
        fin_o.client_id_cut = ccut_nxt;
        fin_o.final_item = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step_i && last_i)) begin
      phase_r <= PH_HEADER;
      pos_r   <= 8'd0;
      hwlen_r <= 8'd0;
      xid_r   <= 24'd0;
      code_r  <= 8'd0;
      left_r  <= 8'd0;
      idx_r   <= 8'd0;
      zs_r    <= 1'b0;
      mal_r   <= 1'b0;
      part_r  <= 1'b0;
      end_r   <= 1'b0;
      hcut_r  <= 1'b0;
      vcut_r  <= 1'b0;
      ccut_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      hwlen_r <= hwlen_nxt;
      xid_r   <= xid_nxt;
      code_r  <= code_nxt;
      left_r  <= left_nxt;
      idx_r   <= idx_nxt;
      zs_r    <= zs_nxt;
      mal_r   <= mal_nxt;
      part_r  <= part_nxt;
      end_r   <= end_nxt;
      hcut_r  <= hcut_nxt;
      vcut_r  <= vcut_nxt;
      ccut_r  <= ccut_nxt;
    end
  end

endmodule

### rtl/dhcp_message_field_extractor.sv
// Top level of the DHCP message field extractor: input register, parser, result queue.
//
//   channel  direction  handshake            payload
//   in_      in         in_valid / in_stall  in_data_byte, in_last_byte
//   out_     out        out_valid/out_stall  out_kind ... out_final_item
//   cfg_     in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One byte per cycle while in_stall is low; each byte is registered, parsed, then queued for output.
// A byte makes at most two results (a fact and the final word); the output
// queue drains one per cycle while out_stall is low, so a run of two-result bytes is paced by it.
// rst_n is synchronous; config registers go to 64/64/32, message state clears.
// out_stall backs up into the 4-entry queue, then holds the input register.
module dhcp_message_field_extractor import dmfe_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_kind,
  output logic [7:0]  out_element_index,
  output logic [31:0] out_fact_value,
  output logic [1:0]  out_status,
  output logic        out_options_end_seen,
  output logic        out_hostname_cut,
  output logic        out_vendor_class_cut,
  output logic        out_client_id_cut,
  output logic        out_final_item,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  cfg_t       cfg_r;
  logic       in_v_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;
  logic       step;
  logic       fact_v, fin_v;
  result_t    fact, fin;

  result_t                fifo_mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]     wr_ptr_r, rd_ptr_r, wr_ptr2;
  logic [FIFO_AW:0]       cnt_r;
  logic                   pop;
  logic [1:0]             push_n;
  result_t                head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hostname_cap     <= HOSTNAME_CAP_RST;
      cfg_r.vendor_class_cap <= VENDOR_CAP_RST;
      cfg_r.client_id_max    <= CLIENT_ID_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_HOSTNAME_CAP:  cfg_r.hostname_cap     <= cfg_data;
        CFG_VENDOR_CAP:    cfg_r.vendor_class_cap <= cfg_data;
        CFG_CLIENT_ID_MAX: cfg_r.client_id_max    <= cfg_data;
        default: ;
      endcase
    end
  end

  // the held word moves on once the queue has room for two results
  assign step     = in_v_r && (cnt_r <= (FIFO_AW+1)'(FIFO_DEPTH - 2));
  assign in_stall = in_v_r && !step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (!in_stall) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte_r <= in_data_byte;
      in_last_r <= in_last_byte;
    end
  end

  dmfe_parse u_parse (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_i   (step),
    .byte_i   (in_byte_r),
    .last_i   (in_last_r),
    .cfg_i    (cfg_r),
    .fact_v_o (fact_v),
    .fact_o   (fact),
    .fin_v_o  (fin_v),
    .fin_o    (fin)
  );

  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && !out_stall;
  assign push_n    = {1'b0, fact_v} + {1'b0, fin_v};
  assign wr_ptr2   = fact_v ? wr_ptr_r + FIFO_AW'(1) : wr_ptr_r;

  always_ff @(posedge clk) begin
    if (fact_v) fifo_mem[wr_ptr_r] <= fact;
    if (fin_v)  fifo_mem[wr_ptr2]  <= fin;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + FIFO_AW'(push_n);
      if (pop) rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      cnt_r <= cnt_r + (FIFO_AW+1)'(push_n) - (FIFO_AW+1)'(pop);
    end
  end

  assign head                 = fifo_mem[rd_ptr_r];
  assign out_kind             = head.kind;
  assign out_element_index    = head.element_index;
  assign out_fact_value       = head.fact_value;
  assign out_status           = head.status;
  assign out_options_end_seen = head.options_end_seen;
  assign out_hostname_cut     = head.hostname_cut;
  assign out_vendor_class_cut = head.vendor_class_cut;
  assign out_client_id_cut    = head.client_id_cut;
  assign out_final_item       = head.final_item;

endmodule

### rtl/dmfe_chk.sv
// Port-level checks on the result channel of the DHCP message field extractor.
module dmfe_chk import dmfe_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [3:0]  out_kind,
  input logic [7:0]  out_element_index,
  input logic [31:0] out_fact_value,
  input logic [1:0]  out_status,
  input logic        out_options_end_seen,
  input logic        out_hostname_cut,
  input logic        out_vendor_class_cut,
  input logic        out_client_id_cut,
  input logic        out_final_item
);

  a_final_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_final_item |-> out_kind == KIND_FINAL && out_fact_value == 32'd0
      && out_element_index == 8'd0)
    else $error("final word carries a fact");

  a_fact_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_final_item |-> out_kind != KIND_FINAL && out_status == STAT_OK
      && !out_options_end_seen && !out_hostname_cut && !out_vendor_class_cut
      && !out_client_id_cut)
    else $error("fact word carries status bits");

  a_chaddr_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_CHADDR |-> out_element_index < 8'd16)
    else $error("chaddr index out of range");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind)
      && $stable(out_fact_value) && $stable(out_element_index))
    else $error("stalled result changed");

endmodule

bind dhcp_message_field_extractor dmfe_chk u_dmfe_chk (.*);

### tb/tb.sv
// Self-checking testbench for dhcp_message_field_extractor: DHCP byte stream in, fact words out.
module tb;
  import dmfe_pkg::*;

  localparam int          BY_MODEL    = -1;   // row left to the predictor
  localparam int          HOLD_CYCLES = 80;
  localparam int unsigned RUN_LIMIT   = 1_000_000;
  localparam logic [31:0] COOKIE      = 32'h6382_5363;

  localparam logic [7:0] OPT_PAD       = 8'd0;
  localparam logic [7:0] OPT_HOSTNAME  = 8'd12;
  localparam logic [7:0] OPT_MSGTYPE   = 8'd53;
  localparam logic [7:0] OPT_VENDOR    = 8'd60;
  localparam logic [7:0] OPT_CLIENT_ID = 8'd61;
  localparam logic [7:0] OPT_END       = 8'd255;

  typedef enum logic [2:0] {
    PH_HEADER, PH_CODE, PH_LEN, PH_VALUE, PH_ENDED, PH_SKIP
  } parse_phase_e;

  typedef enum int {
    SH_GOOD, SH_SHORT, SH_BAD_COOKIE, SH_CUT_OPTION, SH_BAD_MSGTYPE, SH_NO_END, SH_TRAILING,
    SH_COUNT
  } shape_e;

  typedef struct {
    logic [7:0] data;
    logic       last;
    int         n_typed;
    result_t    typed0;
    result_t    typed1;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'd0;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  out_kind;
  logic [7:0]  out_element_index;
  logic [31:0] out_fact_value;
  logic [1:0]  out_status;
  logic        out_options_end_seen;
  logic        out_hostname_cut;
  logic        out_vendor_class_cut;
  logic        out_client_id_cut;
  logic        out_final_item;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = 2'd0;
  logic [7:0]  cfg_data = 8'd0;

  dhcp_message_field_extractor dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // parser mirror
  logic [7:0]   cap_host, cap_vend, cid_keep;
  parse_phase_e phase;
  logic [7:0]   hdr_pos, hw_len, opt_code, opt_left, opt_idx;
  logic [23:0]  xid_acc;
  logic         zero_seen, malformed, partial, end_seen, host_cut, vend_cut, cid_cut;

  result_t    fresh_facts[$];
  result_t    facts_due[$];
  logic [7:0] msg_bytes[$];
  dir_row_t   dir_rows[$];

  int          gap_pct = 0;
  int          stall_pct = 0;
  int          hold_req = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  int          bad_words = 0;
  int unsigned cycle_count = 0;

  function automatic result_t fact(input logic [3:0] kind, input logic [7:0] idx,
                                   input logic [31:0] val);
    result_t r;
    r = '0;
    r.kind = kind;
    r.element_index = idx;
    r.fact_value = val;
    return r;
  endfunction

  function automatic result_t closing(input logic [1:0] st);
    result_t r;
    r = '0;
    r.kind = KIND_FINAL;
    r.status = st;
    r.final_item = 1'b1;
    return r;
  endfunction

  function automatic int keep_limit(input logic [7:0] cap);
    return (cap == 0) ? 0 : int'(cap) - 1;
  endfunction

  function automatic string show(input result_t r);
    return $sformatf("kind %0d idx %0d value %h status %0d end %b cut %b%b%b closing %b",
                     r.kind, r.element_index, r.fact_value, r.status, r.options_end_seen,
                     r.hostname_cut, r.vendor_class_cut, r.client_id_cut, r.final_item);
  endfunction

  task automatic clear_message_state();
    phase = PH_HEADER;
    hdr_pos = 8'd0;
    hw_len = 8'd0;
    xid_acc = 24'd0;
    opt_code = 8'd0;
    opt_left = 8'd0;
    opt_idx = 8'd0;
    zero_seen = 1'b0;
    malformed = 1'b0;
    partial = 1'b0;
    end_seen = 1'b0;
    host_cut = 1'b0;
    vend_cut = 1'b0;
    cid_cut = 1'b0;
  endtask

  // Works out the fact words one message byte produces; leaves them in fresh_facts.
  task automatic extract_facts(input logic [7:0] b, input logic last);
    int unsigned p;
    logic [7:0]  v;
    result_t     fin;
    fresh_facts.delete();
    p = 32'(hdr_pos);
    if (phase == PH_HEADER) begin
      if (p == 0) fresh_facts.push_back(fact(KIND_OP, 8'd0, {24'd0, b}));
      else if (p == 1) fresh_facts.push_back(fact(KIND_HTYPE, 8'd0, {24'd0, b}));
      else if (p == 2) begin
        hw_len = b;
        if (b > 16) malformed = 1'b1;
        fresh_facts.push_back(fact(KIND_HLEN, 8'd0, {24'd0, b}));
      end else if (p >= 4 && p <= 6) xid_acc = {xid_acc[15:0], b};
      else if (p == 7) fresh_facts.push_back(fact(KIND_XID, 8'd0, {xid_acc, b}));
      else if (p >= 28 && p < 44) begin
        if (hw_len <= 16 && (p - 28) < 32'(hw_len))
          fresh_facts.push_back(fact(KIND_CHADDR, 8'(p - 28), {24'd0, b}));
      end else if (p >= 236) begin
        if (COOKIE[8 * (239 - p) +: 8] != b) malformed = 1'b1;
      end
      if (p >= 239) phase = malformed ? PH_SKIP : PH_CODE;
      else hdr_pos = 8'(p + 1);
    end else if (phase == PH_CODE) begin
      if (b == OPT_END) begin
        end_seen = 1'b1;
        phase = PH_ENDED;
      end else if (b != OPT_PAD) begin
        opt_code = b;
        phase = PH_LEN;
      end
    end else if (phase == PH_LEN) begin
      if (opt_code == OPT_MSGTYPE && b != 1) begin
        malformed = 1'b1;
        phase = PH_SKIP;
      end else begin
        // cut flags follow the latest option of their kind, partial sticks
        if (opt_code == OPT_HOSTNAME) host_cut = int'(b) > keep_limit(cap_host);
        else if (opt_code == OPT_VENDOR) vend_cut = int'(b) > keep_limit(cap_vend);
        else if (opt_code == OPT_CLIENT_ID) cid_cut = b > cid_keep;
        if ((opt_code == OPT_HOSTNAME && host_cut) || (opt_code == OPT_VENDOR && vend_cut) ||
            (opt_code == OPT_CLIENT_ID && cid_cut))
          partial = 1'b1;
        zero_seen = 1'b0;
        opt_idx = 8'd0;
        opt_left = b;
        phase = (b == 0) ? PH_CODE : PH_VALUE;
      end
    end else if (phase == PH_VALUE) begin
      if (opt_code == OPT_HOSTNAME) begin
        if (b == 0) zero_seen = 1'b1;
        if (int'(opt_idx) < keep_limit(cap_host)) begin
          v = b;
          if (!zero_seen && b >= "A" && b <= "Z") v = b + 8'd32;
          fresh_facts.push_back(fact(KIND_HOSTNAME, opt_idx, {24'd0, v}));
        end
      end else if (opt_code == OPT_MSGTYPE) begin
        fresh_facts.push_back(fact(KIND_MSGTYPE, 8'd0, {24'd0, b}));
      end else if (opt_code == OPT_VENDOR) begin
        if (int'(opt_idx) < keep_limit(cap_vend))
          fresh_facts.push_back(fact(KIND_VENDOR, opt_idx, {24'd0, b}));
      end else if (opt_code == OPT_CLIENT_ID) begin
        if (opt_idx < cid_keep) fresh_facts.push_back(fact(KIND_CLIENTID, opt_idx, {24'd0, b}));
      end
      opt_idx = opt_idx + 8'd1;
      opt_left = opt_left - 8'd1;
      if (opt_left == 0) phase = PH_CODE;
    end
    if (last) begin
      if (phase == PH_HEADER || phase == PH_LEN || phase == PH_VALUE) malformed = 1'b1;
      fin = closing(malformed ? STAT_MALFORMED : partial ? STAT_PARTIAL : STAT_OK);
      fin.options_end_seen = end_seen;
      fin.hostname_cut = host_cut;
      fin.vendor_class_cut = vend_cut;
      fin.client_id_cut = cid_cut;
      fresh_facts.push_back(fin);
      clear_message_state();
    end
  endtask

  task automatic send_word(input logic [7:0] b, input logic last, input int typed_n,
                           input result_t typed0, input result_t typed1);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= last;
    do @(posedge clk); while (in_stall);
    extract_facts(b, last);
    if (typed_n == BY_MODEL) begin
      foreach (fresh_facts[k]) facts_due.push_back(fresh_facts[k]);
    end else begin
      if (typed_n > 0) facts_due.push_back(typed0);
      if (typed_n > 1) facts_due.push_back(typed1);
    end
  endtask

  task automatic add_row(input logic [7:0] d, input logic l, input int n,
                         input result_t e0, input result_t e1);
    dir_row_t row;
    row.data = d;
    row.last = l;
    row.n_typed = n;
    row.typed0 = e0;
    row.typed1 = e1;
    dir_rows.push_back(row);
  endtask

  task automatic put_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_caps(input logic [7:0] h, input logic [7:0] v, input logic [7:0] c);
    put_reg(CFG_HOSTNAME_CAP, h);
    put_reg(CFG_VENDOR_CAP, v);
    put_reg(CFG_CLIENT_ID_MAX, c);
    cfg_valid <= 1'b0;
    cap_host = h;
    cap_vend = v;
    cid_keep = c;
  endtask

  // Sender stops until every fact word is back, then lets the pipe empty.
  task automatic settle();
    in_valid <= 1'b0;
    while (facts_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_code();
    case ($urandom_range(6))
      0: return OPT_PAD;
      1, 2: return OPT_HOSTNAME;
      3: return OPT_MSGTYPE;
      4: return OPT_VENDOR;
      5: return OPT_CLIENT_ID;
      default: return 8'($urandom_range(254, 1));
    endcase
  endfunction

  // Lengths cluster around the cap so both sides of every cut get hit.
  function automatic int option_len(input logic [7:0] code);
    int keep_n;
    int r;
    int len;
    r = $urandom_range(9);
    if (code == OPT_MSGTYPE) return 1;
    keep_n = (code == OPT_HOSTNAME) ? keep_limit(cap_host) :
             (code == OPT_VENDOR) ? keep_limit(cap_vend) :
             (code == OPT_CLIENT_ID) ? int'(cid_keep) : 4;
    if (r < 5) return $urandom_range(8);
    if (r < 8) begin
      len = keep_n + int'($urandom_range(4)) - 2;
      if (len < 0) len = 0;
      if (len > 255) len = 255;
      return len;
    end
    if (r < 9) return 255;
    return $urandom_range(255);
  endfunction

  task automatic append_option(input logic [7:0] code, input int len);
    msg_bytes.push_back(code);
    if (code != OPT_PAD && code != OPT_END) begin
      msg_bytes.push_back(8'(len));
      repeat (len) begin
        if (code == OPT_HOSTNAME) begin
          case ($urandom_range(7))
            0, 1, 2: msg_bytes.push_back("A" + 8'($urandom_range(25)));
            3, 4: msg_bytes.push_back("a" + 8'($urandom_range(25)));
            5: msg_bytes.push_back(8'd0);
            default: msg_bytes.push_back(8'($urandom));
          endcase
        end else begin
          msg_bytes.push_back(8'($urandom));
        end
      end
    end
  endtask

  task automatic build_message(input shape_e shape);
    int         len;
    int         keep;
    logic [7:0] code;
    msg_bytes.delete();
    repeat (236) msg_bytes.push_back(8'($urandom));
    if ($urandom_range(99) < 15) msg_bytes[2] = 8'($urandom_range(255, 17));
    else msg_bytes[2] = 8'($urandom_range(16));
    for (int i = 3; i >= 0; i--) msg_bytes.push_back(COOKIE[8 * i +: 8]);
    if (shape == SH_BAD_COOKIE) begin
      keep = 236 + $urandom_range(3);
      msg_bytes[keep] = msg_bytes[keep] ^ 8'($urandom_range(255, 1));
    end
    if (shape == SH_SHORT) begin
      len = ($urandom_range(99) < 80) ? $urandom_range(48, 1) : $urandom_range(240, 49);
      while (msg_bytes.size() > len) void'(msg_bytes.pop_back());
      return;
    end
    repeat ($urandom_range(2)) begin
      code = pick_code();
      append_option(code, option_len(code));
    end
    case (shape)
      SH_GOOD, SH_BAD_COOKIE: append_option(OPT_END, 0);
      SH_TRAILING: begin
        append_option(OPT_END, 0);
        repeat ($urandom_range(20, 1)) msg_bytes.push_back(8'($urandom));
      end
      SH_BAD_MSGTYPE: begin
        append_option(OPT_MSGTYPE, ($urandom_range(3) == 0) ? 0 : $urandom_range(9, 2));
        repeat ($urandom_range(10)) msg_bytes.push_back(8'($urandom));
      end
      SH_CUT_OPTION: begin
        code = pick_code();
        if (code == OPT_PAD) code = OPT_HOSTNAME;
        len = option_len(code);
        if (len == 0) len = 1;
        append_option(code, len);
        // stop right after the code byte, or anywhere up to one short of the value
        keep = $urandom_range(1 + len, 1);
        repeat (2 + len - keep) void'(msg_bytes.pop_back());
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin : check_words
    result_t got;
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_kind, out_element_index, out_fact_value, out_status, out_options_end_seen,
             out_hostname_cut, out_vendor_class_cut, out_client_id_cut, out_final_item};
      if (facts_due.size() == 0) begin
        bad_words++;
        if (bad_words <= 10) $display("unexpected word: %s", show(got));
      end else begin
        want = facts_due.pop_front();
        if (got !== want) begin
          bad_words++;
          if (bad_words <= 10)
            $display("mismatch\n  expected %s\n  actual   %s", show(want), show(got));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  initial begin : stimulus
    int     msg_no;
    int     r;
    shape_e shape;
    cap_host = HOSTNAME_CAP_RST;
    cap_vend = VENDOR_CAP_RST;
    cid_keep = CLIENT_ID_RST;
    clear_message_state();

    // lone byte: op, then the closing word flags the short header
    add_row(8'hFF, 1'b1, 2, fact(KIND_OP, 8'd0, 32'hFF), closing(STAT_MALFORMED));
    // zero op/htype, hlen 255, xid all ones, cut after the xid
    add_row(8'h00, 1'b0, 1, fact(KIND_OP, 8'd0, 32'h0), '0);
    add_row(8'h00, 1'b0, 1, fact(KIND_HTYPE, 8'd0, 32'h0), '0);
    add_row(8'hFF, 1'b0, 1, fact(KIND_HLEN, 8'd0, 32'hFF), '0);
    add_row(8'h00, 1'b0, 0, '0, '0);
    repeat (3) add_row(8'hFF, 1'b0, 0, '0, '0);
    add_row(8'hFF, 1'b1, 2, fact(KIND_XID, 8'd0, 32'hFFFF_FFFF), closing(STAT_MALFORMED));
    add_row(8'h01, 1'b0, BY_MODEL, '0, '0);
    add_row(8'h01, 1'b0, BY_MODEL, '0, '0);
    add_row(8'h06, 1'b0, BY_MODEL, '0, '0);
    add_row(8'h00, 1'b0, BY_MODEL, '0, '0);
    add_row(8'hDE, 1'b0, BY_MODEL, '0, '0);
    add_row(8'hAD, 1'b0, BY_MODEL, '0, '0);
    add_row(8'hBE, 1'b0, BY_MODEL, '0, '0);
    add_row(8'hEF, 1'b1, BY_MODEL, '0, '0);
    // hlen one past the chaddr size, message ends on it
    add_row(8'h02, 1'b0, 1, fact(KIND_OP, 8'd0, 32'h2), '0);
    add_row(8'h01, 1'b0, 1, fact(KIND_HTYPE, 8'd0, 32'h1), '0);
    add_row(8'h11, 1'b1, 2, fact(KIND_HLEN, 8'd0, 32'h11), closing(STAT_MALFORMED));
    add_row(8'h80, 1'b0, 1, fact(KIND_OP, 8'd0, 32'h80), '0);
    add_row(8'h7F, 1'b1, 2, fact(KIND_HTYPE, 8'd0, 32'h7F), closing(STAT_MALFORMED));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i])
      send_word(dir_rows[i].data, dir_rows[i].last, dir_rows[i].n_typed,
                dir_rows[i].typed0, dir_rows[i].typed1);

    msg_no = 0;
    for (int ph = 0; ph < 6; ph++) begin
      settle();
      case (ph % 4)
        0: begin gap_pct = 0;  stall_pct <= 0;  end
        1: begin gap_pct = 67; stall_pct <= 0;  end
        2: begin gap_pct = 0;  stall_pct <= 67; end
        default: begin gap_pct = 21; stall_pct <= 21; end
      endcase
      case (ph)
        0: ;  // reset values
        1: load_caps(8'd1, 8'd1, 8'd0);
        2: load_caps(8'd255, 8'd255, 8'd255);
        3: load_caps(8'd0, 8'd0, 8'd0);
        default: load_caps(8'($urandom_range(12, 1)), 8'($urandom_range(12, 1)),
                           8'($urandom_range(12)));
      endcase
      for (int m = 0; m < ((ph == 1) ? 2 : 1); m++) begin
        // long output hold while bytes keep coming: queue and input register fill up
        if (ph == 0 && m == 0) hold_req <= hold_req + 1;
        if (msg_no < SH_COUNT) begin
          shape = shape_e'(msg_no);
        end else begin
          r = $urandom_range(99);
          shape = (r < 35) ? SH_GOOD : (r < 55) ? SH_SHORT : (r < 65) ? SH_CUT_OPTION :
                  (r < 73) ? SH_BAD_COOKIE : (r < 80) ? SH_BAD_MSGTYPE :
                  (r < 90) ? SH_NO_END : SH_TRAILING;
        end
        build_message(shape);
        foreach (msg_bytes[i])
          send_word(msg_bytes[i], i == msg_bytes.size() - 1, BY_MODEL, '0, '0);
        msg_no++;
      end
    end

    in_valid <= 1'b0;
    while (facts_due.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (bad_words == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end

endmodule
